// File: sv/sts_pkg.sv
// ----------------------------------------------------------------------------
// sts_pkg: shared types and constants for the script token scanner
// Request and result structs, token kinds, character classes, keyword table.
// ----------------------------------------------------------------------------
`default_nettype none

package sts_pkg;

   localparam int POSITION_BITS = 32;
   localparam int LENGTH_BITS   = 16;
   localparam int KIND_BITS     = 5;
   localparam int KW_COUNT      = 5;
   localparam int KW_MAX_LEN    = 8;
   localparam int QUEUE_DEPTH   = 4;
   localparam int QUEUE_AW      = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CW      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;

   localparam logic [KIND_BITS-1:0] KIND_END     = 5'd0;
   localparam logic [KIND_BITS-1:0] KIND_BANG    = 5'd1;
   localparam logic [KIND_BITS-1:0] KIND_INC     = 5'd2;
   localparam logic [KIND_BITS-1:0] KIND_DEC     = 5'd3;
   localparam logic [KIND_BITS-1:0] KIND_KW_BASE = 5'd4;
   localparam logic [KIND_BITS-1:0] KIND_PLUS    = 5'd9;
   localparam logic [KIND_BITS-1:0] KIND_MINUS   = 5'd10;
   localparam logic [KIND_BITS-1:0] KIND_ASSIGN  = 5'd11;
   localparam logic [KIND_BITS-1:0] KIND_SEMI    = 5'd12;
   localparam logic [KIND_BITS-1:0] KIND_COMMA   = 5'd13;
   localparam logic [KIND_BITS-1:0] KIND_LPAREN  = 5'd14;
   localparam logic [KIND_BITS-1:0] KIND_RPAREN  = 5'd15;
   localparam logic [KIND_BITS-1:0] KIND_LBRACE  = 5'd16;
   localparam logic [KIND_BITS-1:0] KIND_RBRACE  = 5'd17;
   localparam logic [KIND_BITS-1:0] KIND_INT     = 5'd18;
   localparam logic [KIND_BITS-1:0] KIND_IDENT   = 5'd19;
   localparam logic [KIND_BITS-1:0] KIND_ERROR   = 5'd20;

   localparam logic ACTION_CHAR = 1'b0;
   localparam logic ACTION_END  = 1'b1;

   localparam logic [7:0] KW_TEXT [KW_COUNT][KW_MAX_LEN] = '{
      '{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{"w", "h", "i", "l", "e", 8'h00, 8'h00, 8'h00},
      '{"f", "u", "n", "c", "t", "i", "o", "n"},
      '{"r", "e", "t", "u", "r", "n", 8'h00, 8'h00},
      '{"b", "r", "e", "a", "k", 8'h00, 8'h00, 8'h00}
   };
   localparam logic [3:0] KW_LEN [KW_COUNT] = '{4'd2, 4'd5, 4'd8, 4'd6, 4'd5};

   typedef enum logic [6:0] {
      CL_NONE    = 7'b0000001,
      CL_PLUS    = 7'b0000010,
      CL_MINUS   = 7'b0000100,
      CL_SLASH   = 7'b0001000,
      CL_COMMENT = 7'b0010000,
      CL_INT     = 7'b0100000,
      CL_IDENT   = 7'b1000000
   } class_type;

   typedef struct packed {
      logic       action;
      logic [7:0] char_code;
   } req_type;

   typedef struct packed {
      logic [KIND_BITS-1:0]     kind;
      logic [POSITION_BITS-1:0] start_offset;
      logic [LENGTH_BITS-1:0]   token_length;
      logic [POSITION_BITS-1:0] line_number;
      logic                     last_of_run;
   } rsp_type;

   typedef struct packed {
      logic [1:0] count;
      rsp_type    first;
      rsp_type    second;
   } push_type;

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= "0") && (c <= "9");
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
   endfunction

   function automatic logic is_vert(input logic [7:0] c);
      return (c == 8'h0A) || (c == 8'h0D);
   endfunction

   function automatic logic is_white(input logic [7:0] c);
      return (c == " ") || (c == 8'h09) || (c == 8'h0B) || (c == 8'h0C) || is_vert(c);
   endfunction

   // single-character punctuator kind, KIND_END when none
   function automatic logic [KIND_BITS-1:0] punct_kind(input logic [7:0] c);
      logic [KIND_BITS-1:0] k;
      unique case (c)
         "!":     k = KIND_BANG;
         "=":     k = KIND_ASSIGN;
         ";":     k = KIND_SEMI;
         ",":     k = KIND_COMMA;
         "(":     k = KIND_LPAREN;
         ")":     k = KIND_RPAREN;
         "{":     k = KIND_LBRACE;
         "}":     k = KIND_RBRACE;
         default: k = KIND_END;
      endcase
      return k;
   endfunction

endpackage

`default_nettype wire

// File: sv/sts_scan.sv
// ----------------------------------------------------------------------------
// sts_scan: pending-token state and per-character scan logic
// Updates the pending token on each accepted request and forms up to two tokens.
// ----------------------------------------------------------------------------
`default_nettype none

module sts_scan import sts_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    accept,
   input  wire req_type req,
   output push_type     push
);

   class_type                pclass_ff, pclass_in;
   logic [KW_COUNT-1:0]      kwc_ff, kwc_in;
   logic [POSITION_BITS-1:0] pstart_ff, pstart_in;
   logic [LENGTH_BITS-1:0]   plen_ff, plen_in;
   logic [POSITION_BITS-1:0] pline_ff, pline_in;
   logic [POSITION_BITS-1:0] pos_ff, pos_in;
   logic [POSITION_BITS-1:0] line_ff, line_in;

   logic                 a_valid, b_valid, absorbed, kw_hit;
   logic [KIND_BITS-1:0] a_kind, b_kind, ident_kind, p_kind;
   logic [LENGTH_BITS-1:0] a_len, b_len, grown;
   logic [2:0]           kw_idx;
   logic [KW_COUNT-1:0]  kw_next, kw_first;
   logic [7:0]           c;
   rsp_type              res_a, res_b;

   assign c     = req.char_code;
   assign grown = (plen_ff == LEN_MAX) ? plen_ff : plen_ff + LENGTH_BITS'(1);

   always_comb begin
      kw_hit   = 1'b0;
      kw_idx   = '0;
      kw_next  = '0;
      kw_first = '0;
      for (int k = KW_COUNT - 1; k >= 0; k--) begin
         if (kwc_ff[k] && (plen_ff == LENGTH_BITS'(KW_LEN[k]))) begin
            kw_hit = 1'b1;
            kw_idx = 3'(k);
         end
         if (kwc_ff[k] && (plen_ff < LENGTH_BITS'(KW_LEN[k]))
             && (KW_TEXT[k][plen_ff[2:0]] == c)) begin
            kw_next[k] = 1'b1;
         end
         if (KW_TEXT[k][0] == c) begin
            kw_first[k] = 1'b1;
         end
      end
      ident_kind = kw_hit ? KIND_KW_BASE + KIND_BITS'(kw_idx) : KIND_IDENT;
      p_kind     = punct_kind(c);
   end

   always_comb begin
      pclass_in = pclass_ff;
      kwc_in    = kwc_ff;
      pstart_in = pstart_ff;
      plen_in   = plen_ff;
      pline_in  = pline_ff;
      pos_in    = pos_ff;
      line_in   = line_ff;
      a_valid   = 1'b0;
      a_kind    = KIND_END;
      a_len     = plen_ff;
      b_valid   = 1'b0;
      b_kind    = KIND_ERROR;
      b_len     = LENGTH_BITS'(1);
      absorbed  = 1'b0;
      if (req.action == ACTION_END) begin
         a_len = LENGTH_BITS'(1);
         unique case (pclass_ff)
            CL_PLUS:  begin a_valid = 1'b1; a_kind = KIND_PLUS;  end
            CL_MINUS: begin a_valid = 1'b1; a_kind = KIND_MINUS; end
            CL_SLASH: begin a_valid = 1'b1; a_kind = KIND_ERROR; end
            CL_INT:   begin a_valid = 1'b1; a_kind = KIND_INT;   a_len = plen_ff; end
            CL_IDENT: begin a_valid = 1'b1; a_kind = ident_kind; a_len = plen_ff; end
            default:  ;
         endcase
         b_valid   = 1'b1;
         b_kind    = KIND_END;
         b_len     = '0;
         pclass_in = CL_NONE;
         kwc_in    = '0;
         pstart_in = '0;
         plen_in   = '0;
         pline_in  = '0;
         pos_in    = '0;
         line_in   = '0;
      end else begin
         unique case (pclass_ff)
            CL_PLUS, CL_MINUS: begin
               a_valid = 1'b1;
               if (c == ((pclass_ff == CL_PLUS) ? "+" : "-")) begin
                  absorbed = 1'b1;
                  a_len    = LENGTH_BITS'(2);
                  a_kind   = (pclass_ff == CL_PLUS) ? KIND_INC : KIND_DEC;
               end else begin
                  a_len  = LENGTH_BITS'(1);
                  a_kind = (pclass_ff == CL_PLUS) ? KIND_PLUS : KIND_MINUS;
               end
            end
            CL_SLASH: begin
               if (c == "/") begin
                  absorbed  = 1'b1;
                  pclass_in = CL_COMMENT;
               end else begin
                  a_valid = 1'b1;
                  a_len   = LENGTH_BITS'(1);
                  a_kind  = KIND_ERROR;
               end
            end
            CL_COMMENT: begin
               absorbed = 1'b1;
               if (is_vert(c)) begin
                  pclass_in = CL_NONE;
               end
            end
            CL_INT: begin
               if (is_digit(c)) begin
                  absorbed = 1'b1;
                  plen_in  = grown;
               end else begin
                  a_valid = 1'b1;
                  a_kind  = KIND_INT;
               end
            end
            CL_IDENT: begin
               if (is_alpha(c) || is_digit(c)) begin
                  absorbed = 1'b1;
                  kwc_in   = kw_next;
                  plen_in  = grown;
               end else if ((c == "_") && !kw_hit) begin
                  absorbed = 1'b1;
                  kwc_in   = '0;
                  plen_in  = grown;
               end else begin
                  a_valid = 1'b1;
                  a_kind  = ident_kind;
               end
            end
            default: ;
         endcase
         if (a_valid) begin
            pclass_in = CL_NONE;
            kwc_in    = '0;
            plen_in   = '0;
         end
         if (!absorbed && !is_white(c)) begin
            if (p_kind != KIND_END) begin
               b_valid = 1'b1;
               b_kind  = p_kind;
            end else if ((c == "+") || (c == "-") || (c == "/") || is_digit(c)
                         || is_alpha(c)) begin
               pstart_in = pos_ff;
               pline_in  = line_ff;
               plen_in   = LENGTH_BITS'(1);
               kwc_in    = '0;
               if (c == "+") begin
                  pclass_in = CL_PLUS;
               end else if (c == "-") begin
                  pclass_in = CL_MINUS;
               end else if (c == "/") begin
                  pclass_in = CL_SLASH;
               end else if (is_digit(c)) begin
                  pclass_in = CL_INT;
               end else begin
                  pclass_in = CL_IDENT;
                  kwc_in    = kw_first;
               end
            end else begin
               b_valid = 1'b1;
               b_kind  = KIND_ERROR;
            end
         end
         pos_in = pos_ff + POSITION_BITS'(1);
         if (is_vert(c)) begin
            line_in = line_ff + POSITION_BITS'(1);
         end
      end
   end

   always_comb begin
      res_a.kind         = a_kind;
      res_a.start_offset = pstart_ff;
      res_a.token_length = a_len;
      res_a.line_number  = pline_ff;
      res_a.last_of_run  = !b_valid;
      res_b.kind         = b_kind;
      res_b.start_offset = pos_ff;
      res_b.token_length = b_len;
      res_b.line_number  = line_ff;
      res_b.last_of_run  = 1'b1;
      push.count  = accept ? {a_valid & b_valid, a_valid ^ b_valid} : 2'd0;
      push.first  = a_valid ? res_a : res_b;
      push.second = res_b;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pclass_ff <= CL_NONE;
         kwc_ff    <= '0;
         pstart_ff <= '0;
         plen_ff   <= '0;
         pline_ff  <= '0;
         pos_ff    <= '0;
         line_ff   <= '0;
      end else if (accept) begin
         pclass_ff <= pclass_in;
         kwc_ff    <= kwc_in;
         pstart_ff <= pstart_in;
         plen_ff   <= plen_in;
         pline_ff  <= pline_in;
         pos_ff    <= pos_in;
         line_ff   <= line_in;
      end
   end

endmodule

`default_nettype wire

// File: sv/sts_queue.sv
// ----------------------------------------------------------------------------
// sts_queue: result queue
// Takes up to two tokens per cycle and releases one token per cycle on each pop.
// ----------------------------------------------------------------------------
`default_nettype none

module sts_queue import sts_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire push_type push,
   input  wire logic     pop,
   output rsp_type       head,
   output logic [QUEUE_CW-1:0] count
);

   rsp_type               mem [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CW-1:0]   count_ff, count_in;
   logic [QUEUE_AW-1:0]   wr_next;

   assign wr_next   = wr_ptr_ff + QUEUE_AW'(1);
   assign wr_ptr_in = wr_ptr_ff + QUEUE_AW'(push.count);
   assign rd_ptr_in = rd_ptr_ff + QUEUE_AW'(pop);
   assign count_in  = count_ff + QUEUE_CW'(push.count) - QUEUE_CW'(pop);
   assign head      = mem[rd_ptr_ff];
   assign count     = count_ff;

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         mem[wr_next] <= push.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

// File: sv/script_token_scanner.sv
// ----------------------------------------------------------------------------
// script_token_scanner: streaming tokenizer for a small script language
// One character or end-of-input request per cycle in while not stalled, tokens out.
// ----------------------------------------------------------------------------
// Takes one request per clock cycle while req_stall is low. A request's tokens (zero,
// one or two) are written into a four-entry result queue at the accepting edge and
// leave it on rsp_ one token per cycle while rsp_stall is low. The queue output port
// sets the sustained rate: each token is popped separately, so streams with mostly
// one token per character run at one request per cycle.
// req_stall rises while fewer than two queue entries are free.
`default_nettype none

module script_token_scanner import sts_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   logic                req_accept, rsp_pop;
   push_type            push;
   logic [QUEUE_CW-1:0] count;

   assign req_stall  = count > QUEUE_CW'(QUEUE_DEPTH - 2);
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid  = count != '0;
   assign rsp_pop    = rsp_valid && !rsp_stall;

   sts_scan u_scan (
      .clock  (clock),
      .reset  (reset),
      .accept (req_accept),
      .req    (req_data),
      .push   (push)
   );

   sts_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (rsp_pop),
      .head  (rsp_data),
      .count (count)
   );

endmodule

`default_nettype wire

// File: sv/sts_checker.sv
// ----------------------------------------------------------------------------
// sts_checker: port-level checks for the script token scanner
// Watches the request and result channels; bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module sts_checker import sts_pkg::*; (
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_valid,
   input wire logic    req_stall,
   input wire logic    rsp_valid,
   input wire logic    rsp_stall,
   input wire rsp_type rsp_data
);

   a_empty_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("queue not empty after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled token changed");

   a_end_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.kind == KIND_END)
      |-> (rsp_data.token_length == '0) && rsp_data.last_of_run)
      else $error("end token malformed");

   a_token_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.kind != KIND_END) |-> rsp_data.token_length != '0)
      else $error("token with zero length");

   a_no_accept_idle: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid && !(req_valid && !req_stall) |=> !rsp_valid)
      else $error("token appeared without a request");

endmodule

bind script_token_scanner sts_checker u_sts_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

`default_nettype wire
